// ===== hdl/drb_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the dead-reckoning block.
// Used by every module in this folder; depends on nothing.
`default_nettype none

package drb_pkg;

	localparam int ATAN_LEN = 30;
	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);

	// Inverse CORDIC gain as a Q2.30 value.
	localparam logic signed [31:0] KINV = 32'sd652032874;

	// Angles in Q10.7 degrees.
	localparam logic signed [17:0] DEG90 = 18'sd11520;
	localparam logic signed [17:0] DEG180 = 18'sd23040;
	localparam logic signed [17:0] DEG360 = 18'sd46080;

	// 180 degrees with 20 fraction bits.
	localparam logic signed [30:0] Z180 = 31'sd188743680;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;

	typedef struct packed {
		logic               restart;
		logic signed [20:0] step_len;
		logic signed [30:0] ang;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} drb_item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} drb_qstat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT,
		S_MULX,
		S_MULY,
		S_POS,
		S_VINIT,
		S_VEC,
		S_MULH,
		S_MULL,
		S_MULO,
		S_RNG,
		S_DONE
	} drb_state_t;

	// atan(2^-i) in degrees with 20 fraction bits.
	function automatic logic [25:0] atan_deg(input logic [4:0] i);
		case (i)
			5'd0:  atan_deg = 26'd47185920;
			5'd1:  atan_deg = 26'd27855475;
			5'd2:  atan_deg = 26'd14718068;
			5'd3:  atan_deg = 26'd7471121;
			5'd4:  atan_deg = 26'd3750058;
			5'd5:  atan_deg = 26'd1876857;
			5'd6:  atan_deg = 26'd938658;
			5'd7:  atan_deg = 26'd469357;
			5'd8:  atan_deg = 26'd234682;
			5'd9:  atan_deg = 26'd117342;
			5'd10: atan_deg = 26'd58671;
			5'd11: atan_deg = 26'd29335;
			5'd12: atan_deg = 26'd14668;
			5'd13: atan_deg = 26'd7334;
			5'd14: atan_deg = 26'd3667;
			5'd15: atan_deg = 26'd1833;
			5'd16: atan_deg = 26'd917;
			5'd17: atan_deg = 26'd458;
			5'd18: atan_deg = 26'd229;
			5'd19: atan_deg = 26'd115;
			5'd20: atan_deg = 26'd57;
			5'd21: atan_deg = 26'd29;
			5'd22: atan_deg = 26'd14;
			5'd23: atan_deg = 26'd7;
			5'd24: atan_deg = 26'd4;
			5'd25: atan_deg = 26'd2;
			5'd26: atan_deg = 26'd1;
			default: atan_deg = 26'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hdl/drb_front.sv =====
// Input side: accepts beats and folds the heading into the CORDIC rotation range.
// Depends on drb_pkg for the item type and angle constants.
`default_nettype none

module drb_front (
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                restart,
	input  wire logic signed [15:0]  heading,
	input  wire logic signed [19:0]  travel,
	input  wire logic signed [31:0]  target_x,
	input  wire logic signed [31:0]  target_y,
	input  wire drb_pkg::drb_qstat_t q_stat,
	output logic                     push,
	output drb_pkg::drb_item_t       push_item
);
	import drb_pkg::*;

	logic signed [17:0] h_w;
	logic signed [17:0] h_f;
	logic               fold;
	logic signed [20:0] d_ext;

	assign in_stall = q_stat.full;
	assign push = in_valid && !q_stat.full;

	// Wrap once into +-180, then fold anything beyond +-90 by 180 and flip the travel.
	always_comb begin
		h_w = 18'(heading);
		if (h_w > DEG180) begin
			h_w = h_w - DEG360;
		end else if (h_w < -DEG180) begin
			h_w = h_w + DEG360;
		end
		fold = 1'b0;
		h_f = h_w;
		if (h_w > DEG90) begin
			h_f = h_w - DEG180;
			fold = 1'b1;
		end else if (h_w < -DEG90) begin
			h_f = h_w + DEG180;
			fold = 1'b1;
		end
	end

	assign d_ext = 21'(travel);

	always_comb begin
		push_item.restart = restart;
		push_item.step_len = fold ? -d_ext : d_ext;
		push_item.ang = 31'(h_f) <<< 13;
		push_item.tx = target_x;
		push_item.ty = target_y;
	end

endmodule

`default_nettype wire

// ===== hdl/drb_queue.sv =====
// Short queue of classified items between the input side and the solver.
// Depends on drb_pkg for the item and status types.
`default_nettype none

module drb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire drb_pkg::drb_item_t push_item,
	input  wire logic               pop,
	output drb_pkg::drb_item_t      pop_item,
	output drb_pkg::drb_qstat_t     q_stat
);
	import drb_pkg::*;

	drb_item_t          mem_q [QDEPTH];
	logic [QPW-1:0]     wr_ptr_q;
	logic [QPW-1:0]     rd_ptr_q;
	logic [QPW:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign q_stat.full = (count_q == (QPW+1)'(QDEPTH));
	assign q_stat.valid = (count_q != '0);

endmodule

`default_nettype wire

// ===== hdl/drb_back.sv =====
// Solver: keeps the position and runs one shared CORDIC stage and one constant
// multiplier through rotation, position update and vectoring. Depends on drb_pkg.
`default_nettype none

module drb_back #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire drb_pkg::drb_qstat_t  q_stat,
	input  wire drb_pkg::drb_item_t   q_item,
	output logic                      q_pop,
	input  wire logic signed [31:0]   start_x,
	input  wire logic signed [31:0]   start_y,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic [30:0]               range_to_target,
	output logic signed [15:0]        bearing_to_target,
	output logic                      saturated
);
	import drb_pkg::*;

	localparam int NIT = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
	localparam logic [4:0] ILAST = 5'(NIT - 1);
	localparam int PW = POSITION_WIDTH;
	localparam int DW = ((PW > 32) ? PW : 32) + 1;
	// Difference width plus 8 guard bits plus room for CORDIC growth.
	localparam int VW = DW + 10;
	localparam int MW = 22;
	localparam logic signed [63:0] PMAX = (64'sd1 <<< (PW - 1)) - 64'sd1;
	localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;
	localparam logic [30:0] RMAX = 31'h7FFFFFFF;

	drb_state_t             state_q;
	drb_state_t             state_d;
	logic [4:0]             iter_q;
	logic signed [VW-1:0]   x_q;
	logic signed [VW-1:0]   y_q;
	logic signed [30:0]     z_q;
	logic signed [PW-1:0]   pos_x_q;
	logic signed [PW-1:0]   pos_y_q;
	logic signed [31:0]     tx_q;
	logic signed [31:0]     ty_q;
	logic signed [MW-1:0]   mx_q;
	logic signed [63:0]     prod_q;
	logic [63:0]            acc_q;
	logic [30:0]            range_q;
	logic signed [15:0]     bear_q;
	logic                   flag_q;
	logic                   out_valid_q;

	logic                   iter_last;
	logic                   out_load;
	logic                   ccw;
	logic                   y_pos;
	logic signed [VW-1:0]   xs;
	logic signed [VW-1:0]   ys;
	logic signed [VW-1:0]   x_nx;
	logic signed [VW-1:0]   y_nx;
	logic signed [30:0]     z_nx;
	logic signed [30:0]     atan_v;
	logic signed [31:0]     mul_a;
	logic signed [63:0]     prod_d;
	logic signed [63:0]     rnd_d;
	logic signed [MW-1:0]   my_w;
	logic signed [63:0]     sx;
	logic signed [63:0]     sy;
	logic signed [63:0]     rsx;
	logic signed [63:0]     rsy;
	logic signed [63:0]     dx;
	logic signed [63:0]     dy;
	logic                   tgt_zero;
	logic signed [VW-1:0]   vx_s;
	logic signed [VW-1:0]   vy_s;
	logic [VW-1:0]          xc;
	logic                   rng_big;
	logic signed [30:0]     bz;
	logic signed [17:0]     b18;
	logic signed [17:0]     bw;
	logic [63:0]            rsum;
	logic                   rng_over;
	logic signed [63:0]     pos_x64;
	logic signed [63:0]     pos_y64;

	function automatic logic signed [PW-1:0] sat_pos(input logic signed [63:0] v);
		if (v > PMAX) begin
			sat_pos = PMAX[PW-1:0];
		end else if (v < PMIN) begin
			sat_pos = PMIN[PW-1:0];
		end else begin
			sat_pos = v[PW-1:0];
		end
	endfunction

	function automatic logic clips(input logic signed [63:0] v);
		clips = (v > PMAX) || (v < PMIN);
	endfunction

	// Shared CORDIC micro-rotation. Rotation steers on the sign of z, vectoring on y.
	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign atan_v = 31'(atan_deg(iter_q));
	assign y_pos = !y_q[VW-1] && (|y_q);
	assign ccw = (state_q == S_ROT) ? !z_q[30] : !y_pos;
	assign x_nx = ccw ? x_q - ys : x_q + ys;
	assign y_nx = ccw ? y_q + xs : y_q - xs;
	assign z_nx = ccw ? z_q - atan_v : z_q + atan_v;
	assign iter_last = (iter_q == ILAST);

	// Range path works on the clamped vector length, split into pieces for the multiplier.
	assign xc = x_q[VW-1] ? '0 : x_q;
	assign rng_big = |xc[VW-2:41];

	always_comb begin
		case (state_q)
			S_MULX:  mul_a = x_q[31:0];
			S_MULY:  mul_a = y_q[31:0];
			S_MULH:  mul_a = {16'd0, xc[40:25]};
			S_MULL:  mul_a = {15'd0, xc[24:8]};
			S_MULO:  mul_a = {24'd0, xc[7:0]};
			default: mul_a = '0;
		endcase
	end

	assign prod_d = mul_a * KINV;
	assign rnd_d = (prod_q + (64'sd1 <<< 39)) >>> 40;
	assign my_w = rnd_d[MW-1:0];

	assign sx = 64'(pos_x_q) + 64'(mx_q);
	assign sy = 64'(pos_y_q) + 64'(my_w);
	assign rsx = 64'(start_x);
	assign rsy = 64'(start_y);

	assign dx = 64'(tx_q) - 64'(pos_x_q);
	assign dy = 64'(ty_q) - 64'(pos_y_q);
	assign tgt_zero = (dx == 64'sd0) && (dy == 64'sd0);
	assign vx_s = VW'(dx <<< 8);
	assign vy_s = VW'(dy <<< 8);

	assign bz = (z_q + 31'sd4096) >>> 13;
	assign b18 = bz[17:0];

	always_comb begin
		if (b18 > DEG180) begin
			bw = b18 - DEG360;
		end else if (b18 < -DEG180) begin
			bw = b18 + DEG360;
		end else begin
			bw = b18;
		end
	end

	assign rsum = acc_q + ($unsigned(prod_q) >> 8);
	assign rng_over = |rsum[63:61];

	assign pos_x64 = 64'(pos_x_q);
	assign pos_y64 = 64'(pos_y_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_stat.valid) begin
					state_d = q_item.restart ? S_VINIT : S_ROT;
				end
			end
			S_ROT: begin
				if (iter_last) begin
					state_d = S_MULX;
				end
			end
			S_MULX:  state_d = S_MULY;
			S_MULY:  state_d = S_POS;
			S_POS:   state_d = S_VINIT;
			S_VINIT: state_d = tgt_zero ? S_DONE : S_VEC;
			S_VEC: begin
				if (iter_last) begin
					state_d = S_MULH;
				end
			end
			S_MULH:  state_d = rng_big ? S_DONE : S_MULL;
			S_MULL:  state_d = S_MULO;
			S_MULO:  state_d = S_RNG;
			S_RNG:   state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		q_pop = (state_q == S_IDLE) && q_stat.valid;
		out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_ROT || state_q == S_VEC) && !iter_last) begin
				iter_q <= iter_q + 5'd1;
			end else begin
				iter_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The kept position lives here; reset clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (state_q == S_IDLE && q_stat.valid && q_item.restart) begin
			pos_x_q <= sat_pos(rsx);
			pos_y_q <= sat_pos(rsy);
		end else if (state_q == S_POS) begin
			pos_x_q <= sat_pos(sx);
			pos_y_q <= sat_pos(sy);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_stat.valid) begin
					tx_q <= q_item.tx;
					ty_q <= q_item.ty;
					if (q_item.restart) begin
						flag_q <= clips(rsx) || clips(rsy);
					end else begin
						x_q <= VW'(q_item.step_len) <<< 10;
						y_q <= '0;
						z_q <= q_item.ang;
						flag_q <= 1'b0;
					end
				end
			end
			S_ROT, S_VEC: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			S_MULX: begin
				prod_q <= prod_d;
			end
			S_MULY: begin
				mx_q <= rnd_d[MW-1:0];
				prod_q <= prod_d;
			end
			S_POS: begin
				if (clips(sx) || clips(sy)) begin
					flag_q <= 1'b1;
				end
			end
			S_VINIT: begin
				if (tgt_zero) begin
					range_q <= '0;
					bear_q <= '0;
				end else if (vx_s[VW-1]) begin
					x_q <= -vx_s;
					y_q <= -vy_s;
					z_q <= dy[63] ? -Z180 : Z180;
				end else begin
					x_q <= vx_s;
					y_q <= vy_s;
					z_q <= '0;
				end
			end
			S_MULH: begin
				bear_q <= bw[15:0];
				if (rng_big) begin
					range_q <= RMAX;
					flag_q <= 1'b1;
				end
				prod_q <= prod_d;
			end
			S_MULL: begin
				acc_q <= {prod_q[46:0], 17'd0} + (64'd1 << 29);
				prod_q <= prod_d;
			end
			S_MULO: begin
				acc_q <= acc_q + $unsigned(prod_q);
				prod_q <= prod_d;
			end
			S_RNG: begin
				if (rng_over) begin
					range_q <= RMAX;
					flag_q <= 1'b1;
				end else begin
					range_q <= rsum[60:30];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x <= pos_x64[31:0];
			pos_y <= pos_y64[31:0];
			range_to_target <= range_q;
			bearing_to_target <= bear_q;
			saturated <= flag_q;
		end
	end

	assign out_valid = out_valid_q;

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT || state_q == S_VEC) |-> (iter_q <= ILAST))
		else $error("CORDIC step count ran past the last table entry");

	a_rot_fits_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULX) |-> (x_q[VW-1:31] == {(VW-31){x_q[31]}} &&
			y_q[VW-1:31] == {(VW-31){y_q[31]}}))
		else $error("rotated vector does not fit the multiplier operand");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_load) |=> (state_q == S_DONE && $stable(range_q)
			&& $stable(bear_q) && $stable(flag_q)))
		else $error("finished result changed while waiting for the output register");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bearing_to_target <= 16'sd23040 && bearing_to_target >= -16'sd23040))
		else $error("bearing outside +-180 degrees");

endmodule

`default_nettype wire

// ===== hdl/dead_reckoning_range_bearing.sv =====
// Dead-reckoning position keeper with range and bearing to a target point.
// Top level: start registers and the front, queue and solver instances.
// Each input beat either reloads the kept position from start_x/start_y (restart) or
// moves it by travel along heading (Q8.7 degrees, 0 north, 90 east); the result beat
// carries the new position, the range (Q15.16, saturating) and the atan2 bearing to the
// target. A restart skips the rotation and position update, and a target equal to the
// position skips the vectoring pass and the range multiplies. The time per beat is set by
// the single shared CORDIC stage, which runs the rotation and then the vectoring pass one
// step per cycle, and by the one constant multiplier used for gain correction and range
// scaling. A two-entry queue takes new beats while the solver works, and the output
// register holds a finished result while the solver begins the next beat.
`default_nettype none

module dead_reckoning_range_bearing #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               restart,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [19:0] travel,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [30:0]             range_to_target,
	output logic signed [15:0]      bearing_to_target,
	output logic                    saturated
);
	import drb_pkg::*;

	logic signed [31:0] start_x_q;
	logic signed [31:0] start_y_q;
	logic               push;
	logic               pop;
	drb_item_t          push_item;
	drb_item_t          pop_item;
	drb_qstat_t         q_stat;

	// Writes to an index past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	drb_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.heading   (heading),
		.travel    (travel),
		.target_x  (target_x),
		.target_y  (target_y),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	drb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	drb_back #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS),
		.POSITION_WIDTH    (POSITION_WIDTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.q_item            (pop_item),
		.q_pop             (pop),
		.start_x           (start_x_q),
		.start_y           (start_y_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.range_to_target   (range_to_target),
		.bearing_to_target (bearing_to_target),
		.saturated         (saturated)
	);

endmodule

`default_nettype wire
